// ----- rtl/core/fpd_pkg.sv -----
// ----------------------------------------------------------------------------
// fpd_pkg
// Shared types and constants for the signed 16.16 fixed-point divider.
// ----------------------------------------------------------------------------
package fpd_pkg;

   localparam int unsigned DataW    = 32;
   localparam int unsigned RemW     = DataW + 1;
   localparam int unsigned SatShift = 15;
   localparam int unsigned HiShift  = 14;
   localparam int unsigned LowW     = HiShift;
   localparam int unsigned Steps    = 31;

   localparam logic [DataW-1:0] FxOne = 32'h0001_0000;
   localparam logic [DataW-1:0] FxSat = 32'h7fff_ffff;

   // Control that travels with each item down the cell row.
   typedef struct packed {
      logic valid;  // stage holds an item
      logic fixed;  // result is already final and sits in q
      logic neg;    // sign of the quotient for the divide path
   } fpd_ctrl_type;

   // Working values of one item in the restoring division.
   typedef struct packed {
      logic [RemW-1:0]  rem;  // partial remainder
      logic [LowW-1:0]  low;  // dividend bits not yet shifted in
      logic [DataW-1:0] den;  // divisor magnitude
      logic [DataW-1:0] q;    // quotient bits so far, or the final result
   } fpd_data_type;

endpackage

// ----- rtl/core/fpd_front.sv -----
// ----------------------------------------------------------------------------
// fpd_front
// Operand conditioning: special cases, magnitudes and the saturation test.
// ----------------------------------------------------------------------------
module fpd_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       advance,
   input  logic                       valid_in,
   input  logic [fpd_pkg::DataW-1:0]  dividend,
   input  logic [fpd_pkg::DataW-1:0]  divisor,
   output fpd_pkg::fpd_ctrl_type      ctrl_out,
   output fpd_pkg::fpd_data_type      data_out
);

   fpd_pkg::fpd_ctrl_type ctrl_in, ctrl_ff;
   fpd_pkg::fpd_data_type data_in, data_ff;

   logic [fpd_pkg::DataW-1:0] b_eff;
   logic [fpd_pkg::DataW-1:0] am;
   logic [fpd_pkg::DataW-1:0] bm;
   logic                      neg;
   logic                      sat;

   always_comb begin
      b_eff = (divisor == '0) ? fpd_pkg::FxOne : divisor;
      neg   = dividend[fpd_pkg::DataW-1] ^ b_eff[fpd_pkg::DataW-1];
      am    = dividend[fpd_pkg::DataW-1] ? ('0 - dividend) : dividend;
      bm    = b_eff[fpd_pkg::DataW-1] ? ('0 - b_eff) : b_eff;
      sat   = (am >> fpd_pkg::SatShift) >= bm;

      ctrl_in.valid = valid_in;
      ctrl_in.fixed = 1'b1;
      ctrl_in.neg   = 1'b0;
      data_in.rem   = '0;
      data_in.low   = '0;
      data_in.den   = bm;
      data_in.q     = '0;

      if (dividend == '0) begin
         data_in.q = '0;
      end else if (b_eff == fpd_pkg::FxOne) begin
         data_in.q = dividend;
      end else if (sat) begin
         data_in.q = neg ? ('0 - fpd_pkg::FxSat) : fpd_pkg::FxSat;
      end else begin
         ctrl_in.fixed = 1'b0;
         ctrl_in.neg   = neg;
         data_in.rem   = fpd_pkg::RemW'(am >> fpd_pkg::HiShift);
         data_in.low   = am[fpd_pkg::LowW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else if (advance) begin
         ctrl_ff <= ctrl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

   assign ctrl_out = ctrl_ff;
   assign data_out = data_ff;

endmodule

// ----- rtl/core/fpd_cell.sv -----
// ----------------------------------------------------------------------------
// fpd_cell
// One restoring division step, registered; items with a final result pass.
// ----------------------------------------------------------------------------
module fpd_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  fpd_pkg::fpd_ctrl_type  ctrl_in,
   input  fpd_pkg::fpd_data_type  data_in,
   output fpd_pkg::fpd_ctrl_type  ctrl_out,
   output fpd_pkg::fpd_data_type  data_out
);

   fpd_pkg::fpd_ctrl_type ctrl_ff;
   fpd_pkg::fpd_data_type data_ff;
   fpd_pkg::fpd_data_type step_in;

   logic [fpd_pkg::RemW-1:0]  den_ext;
   logic [fpd_pkg::RemW-1:0]  rem_sub;
   logic [fpd_pkg::DataW-1:0] rem_keep;
   logic                      ge;

   always_comb begin
      den_ext  = {1'b0, data_in.den};
      ge       = data_in.rem >= den_ext;
      rem_sub  = data_in.rem - den_ext;
      // The kept remainder is below the divisor, so it fits in 32 bits.
      rem_keep = ge ? rem_sub[fpd_pkg::DataW-1:0] : data_in.rem[fpd_pkg::DataW-1:0];

      step_in = data_in;
      if (!ctrl_in.fixed) begin
         step_in.rem = {rem_keep, data_in.low[fpd_pkg::LowW-1]};
         step_in.low = {data_in.low[fpd_pkg::LowW-2:0], 1'b0};
         step_in.q   = {data_in.q[fpd_pkg::DataW-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else if (advance) begin
         ctrl_ff <= ctrl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= step_in;
      end
   end

   assign ctrl_out = ctrl_ff;
   assign data_out = data_ff;

endmodule

// ----- rtl/core/fixed_point_divider_16_16_core.sv -----
// ----------------------------------------------------------------------------
// fixed_point_divider_16_16_core
// Signed 16.16 fixed-point divider built as a row of restoring-division cells.
// ----------------------------------------------------------------------------
// The divider takes one beat per cycle while req_stall is low and returns one
// quotient beat for each, in order: each item passes through the operand stage,
// the 31 division cells, one restoring step per cell, and the output register.
// A zero dividend returns zero, a zero divisor is taken as 1.0 so the dividend
// passes through (as it does for a divisor of exactly 1.0), and a quotient
// whose magnitude would reach 2^15 saturates to 0x7fffffff with the proper
// sign. The whole row advances together; while a finished quotient is held
// by rsp_stall the row holds too and req_stall is raised.
module fixed_point_divider_16_16_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_dividend,
   input  logic signed [31:0] req_divisor,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_quotient
);

   // Stage 0 is the operand stage; stages 1 to Steps are the division cells.
   fpd_pkg::fpd_ctrl_type stage_ctrl [0:fpd_pkg::Steps];
   fpd_pkg::fpd_data_type stage_data [0:fpd_pkg::Steps];

   logic                      advance;
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   logic [fpd_pkg::DataW-1:0] rsp_quotient_ff;
   logic [fpd_pkg::DataW-1:0] rsp_quotient_in;

   // The row moves whenever the output register is empty or being taken.
   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;

   fpd_front u_front (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .valid_in (req_valid),
      .dividend (unsigned'(req_dividend)),
      .divisor  (unsigned'(req_divisor)),
      .ctrl_out (stage_ctrl[0]),
      .data_out (stage_data[0])
   );

   for (genvar i = 1; i <= fpd_pkg::Steps; i++) begin : g_cell
      fpd_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .ctrl_in  (stage_ctrl[i-1]),
         .data_in  (stage_data[i-1]),
         .ctrl_out (stage_ctrl[i]),
         .data_out (stage_data[i])
      );
   end

   // The sign goes back on the divide path only; special cases arrive final.
   always_comb begin
      rsp_valid_in    = stage_ctrl[fpd_pkg::Steps].valid;
      rsp_quotient_in = stage_data[fpd_pkg::Steps].q;
      if (!stage_ctrl[fpd_pkg::Steps].fixed && stage_ctrl[fpd_pkg::Steps].neg) begin
         rsp_quotient_in = '0 - stage_data[fpd_pkg::Steps].q;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_quotient_ff <= rsp_quotient_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_quotient = signed'(rsp_quotient_ff);

   // A divide-path item entering the row must not already be saturated:
   // the starting remainder stays below twice the divisor.
   a_front_rem_bound : assert property (@(posedge clock) disable iff (reset)
      (stage_ctrl[0].valid && !stage_ctrl[0].fixed) |->
         (stage_data[0].rem < {stage_data[0].den, 1'b0}))
      else $error("operand stage remainder exceeds twice the divisor");

   // After 31 steps a divide-path quotient magnitude fits in 31 bits.
   a_last_q_msb : assert property (@(posedge clock) disable iff (reset)
      (stage_ctrl[fpd_pkg::Steps].valid && !stage_ctrl[fpd_pkg::Steps].fixed) |->
         !stage_data[fpd_pkg::Steps].q[fpd_pkg::DataW-1])
      else $error("divide-path quotient magnitude overflowed 31 bits");

   // The restoring invariant holds at the end of the row.
   a_last_rem_bound : assert property (@(posedge clock) disable iff (reset)
      (stage_ctrl[fpd_pkg::Steps].valid && !stage_ctrl[fpd_pkg::Steps].fixed) |->
         (stage_data[fpd_pkg::Steps].rem < {stage_data[fpd_pkg::Steps].den, 1'b0}))
      else $error("final remainder exceeds twice the divisor");

   // A held result freezes the row, so the last cell keeps its item.
   a_hold_row : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (stage_ctrl[fpd_pkg::Steps] == $past(stage_ctrl[fpd_pkg::Steps])))
      else $error("division row moved while the output was held");

endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Checks the signed 16.16 divider against a bit-exact quotient predictor.
// A short directed set hits the zero, pass-through, most-negative and
// saturation corners. A random set then mixes wide and narrow operands and
// operand pairs placed near the saturation boundary. Both handshake sides
// idle and stall at random. Every quotient beat is compared in order with
// the predicted value.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   // One predicted quotient, kept with its operands for error reports.
   typedef struct {
      logic [fpd_pkg::DataW-1:0] dividend;
      logic [fpd_pkg::DataW-1:0] divisor;
      logic [fpd_pkg::DataW-1:0] quotient;
   } quot_entry_type;

   // Predicts each quotient when its operand beat is accepted and compares
   // result beats in arrival order. The divider has no state, so the
   // prediction depends on the operand pair alone.
   class fpd_scoreboard;
      quot_entry_type due_q[$];
      int             accepted;
      int             compared;
      int             mismatches;
      int             saturated;
      int             passed_through;

      // Restoring division on magnitudes, with a 33-bit partial remainder.
      function logic [fpd_pkg::DataW-1:0] quotient_of(logic [fpd_pkg::DataW-1:0] a,
                                                      logic [fpd_pkg::DataW-1:0] b);
         logic [fpd_pkg::DataW-1:0] am;
         logic [fpd_pkg::DataW-1:0] bm;
         logic [fpd_pkg::DataW-1:0] mag;
         logic [fpd_pkg::DataW-1:0] low;
         logic [fpd_pkg::RemW-1:0]  rem;
         logic                      neg;
         if (a == '0) begin
            return '0;
         end
         if (b == '0) begin
            b = fpd_pkg::FxOne;
         end
         if (b == fpd_pkg::FxOne) begin
            passed_through++;
            return a;
         end
         neg = a[fpd_pkg::DataW-1] ^ b[fpd_pkg::DataW-1];
         am  = a[fpd_pkg::DataW-1] ? ('0 - a) : a;
         bm  = b[fpd_pkg::DataW-1] ? ('0 - b) : b;
         if ((am >> fpd_pkg::SatShift) >= bm) begin
            saturated++;
            mag = fpd_pkg::FxSat;
         end else begin
            rem = fpd_pkg::RemW'(am >> fpd_pkg::HiShift);
            low = am << (fpd_pkg::DataW - fpd_pkg::HiShift);
            mag = '0;
            for (int k = 0; k < fpd_pkg::Steps; k++) begin
               mag = mag << 1;
               if (rem >= {1'b0, bm}) begin
                  rem    = rem - {1'b0, bm};
                  mag[0] = 1'b1;
               end
               rem = {rem[fpd_pkg::RemW-2:0], low[fpd_pkg::DataW-1]};
               low = low << 1;
            end
         end
         return neg ? ('0 - mag) : mag;
      endfunction

      function void note_operands(logic [fpd_pkg::DataW-1:0] a,
                                  logic [fpd_pkg::DataW-1:0] b);
         quot_entry_type e;
         e.dividend = a;
         e.divisor  = b;
         e.quotient = quotient_of(a, b);
         due_q.push_back(e);
         accepted++;
      endfunction

      function void check_quotient(logic [fpd_pkg::DataW-1:0] got);
         quot_entry_type e;
         if (due_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("%t  unexpected quotient beat %h", $realtime, got);
            end
            return;
         end
         e = due_q.pop_front();
         compared++;
         if (got !== e.quotient) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("%t  quotient mismatch: %h / %h expected %h actual %h",
                        $realtime, e.dividend, e.divisor, e.quotient, got);
            end
         end
      endfunction

      function int pending();
         return due_q.size();
      endfunction
   endclass

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic signed [31:0] req_dividend;
   logic signed [31:0] req_divisor;
   logic               rsp_valid;
   logic               rsp_stall;
   logic signed [31:0] rsp_quotient;

   fpd_scoreboard sb;

   // While calm is set neither side idles, so the row runs at full rate.
   bit calm;
   int stall_left;

   fixed_point_divider_16_16_core dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_dividend (req_dividend),
      .req_divisor  (req_divisor),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_quotient (rsp_quotient)
   );

   initial begin
      clock = 1'b0;
   end

   always #6 clock = ~clock;

   // Both monitors read the values present before the edge, so the accepted
   // beats are seen exactly as the divider sees them.
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         sb.note_operands(req_dividend, req_divisor);
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_quotient(rsp_quotient);
      end
   end

   // Result-side stalls come in short bursts, about one cycle in ten overall.
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (!calm && $urandom_range(99) < 3) begin
         stall_left = $urandom_range(5);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Called at a falling edge; returns at the falling edge after acceptance,
   // so the next beat or idle is the only assignment made at that edge.
   task automatic send_beat(logic [31:0] a, logic [31:0] b);
      req_valid    <= 1'b1;
      req_dividend <= a;
      req_divisor  <= b;
      do begin
         @(posedge clock);
      end while (req_stall);
      @(negedge clock);
   endtask

   task automatic maybe_idle();
      int gap;
      if (!calm && $urandom_range(99) < 5) begin
         gap = $urandom_range(1, 3);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // A value of random magnitude scale and random sign, so that narrow and
   // wide operands both show up often.
   function automatic logic [31:0] scaled_operand();
      logic [31:0] v;
      v = $urandom >> $urandom_range(0, 31);
      if ($urandom_range(1)) begin
         v = '0 - v;
      end
      return v;
   endfunction

   task automatic random_pair(output logic [31:0] a, output logic [31:0] b);
      logic [31:0] bm;
      logic [31:0] am;
      int          pick;
      pick = $urandom_range(0, 19);
      if (pick < 5) begin
         // Full-width noise on both operands.
         a = $urandom;
         b = $urandom;
      end else if (pick < 11) begin
         a = scaled_operand();
         b = scaled_operand();
      end else if (pick < 15) begin
         // Straddle the point where the quotient saturates.
         bm = $urandom_range(1, 32'h0000_ffff);
         am = (bm << fpd_pkg::SatShift) - 1 + $urandom_range(0, 2);
         a  = $urandom_range(1) ? ('0 - am) : am;
         b  = $urandom_range(1) ? ('0 - bm) : bm;
      end else if (pick < 18) begin
         a = $urandom_range(1) ? $urandom : scaled_operand();
         case ($urandom_range(0, 4))
            0:       b = '0;
            1:       b = fpd_pkg::FxOne;
            2:       b = '0 - fpd_pkg::FxOne;
            3:       b = 32'h8000_0000;
            default: b = fpd_pkg::FxOne + $urandom_range(0, 2) - 1;
         endcase
      end else if (pick < 19) begin
         a = '0;
         b = $urandom;
      end else begin
         a = $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
         b = scaled_operand();
      end
   endtask

   initial begin
      logic [31:0] dirs_a[$];
      logic [31:0] dirs_b[$];
      logic [31:0] a;
      logic [31:0] b;

      sb           = new();
      calm         = 1'b0;
      stall_left   = 0;
      reset        <= 1'b1;
      req_valid    <= 1'b0;
      req_dividend <= '0;
      req_divisor  <= '0;
      rsp_stall    <= 1'b0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // Directed corners: zero dividend, zero divisor, divide by plus and
      // minus one, the most negative value on either side, saturation on
      // both sides of its boundary, and a few ordinary fractions.
      dirs_a = '{32'h0000_0000, 32'h0000_0000, 32'h8000_0000, 32'h1234_5678,
                 32'h8000_0000, 32'h7fff_ffff, 32'hffff_0000, 32'h8000_0000,
                 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000,
                 32'h0000_0001, 32'hffff_ffff, 32'h0000_0001, 32'h0003_0000,
                 32'hfffd_0000, 32'h0001_0000, 32'h0040_0000, 32'h0040_0000,
                 32'h1234_5678, 32'h4000_0000, 32'hffc0_0000};
      dirs_b = '{32'h0000_0000, 32'h8000_0000, 32'h0000_0000, 32'h0000_0000,
                 32'h0001_0000, 32'h0001_0000, 32'hffff_0000, 32'hffff_0000,
                 32'h8000_0000, 32'h8000_0000, 32'h0000_0001, 32'h0000_0001,
                 32'h7fff_ffff, 32'h7fff_ffff, 32'hffff_ffff, 32'h0002_0000,
                 32'h0002_0000, 32'h0003_0000, 32'h0000_0080, 32'h0000_0081,
                 32'h0001_0001, 32'hfffe_ffff, 32'hffff_ff81};
      foreach (dirs_a[i]) begin
         maybe_idle();
         send_beat(dirs_a[i], dirs_b[i]);
      end

      for (int n = 0; n < 500; n++) begin
         // One stretch runs back to back on both sides.
         calm = (n >= 100 && n < 200);
         // Halfway through, hold off until the divider has fully drained.
         if (n == 250) begin
            req_valid <= 1'b0;
            while (sb.pending() != 0) @(negedge clock);
         end
         maybe_idle();
         random_pair(a, b);
         send_beat(a, b);
      end
      req_valid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      $display("Divided %0d operand pairs and compared %0d quotients.",
               sb.accepted, sb.compared);
      $display("Of those, %0d saturated and %0d passed the dividend through.",
               sb.saturated, sb.passed_through);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("status: pass");
      end else begin
         $display("%0d quotient errors, %0d still outstanding.",
                  sb.mismatches, sb.pending());
         $display("status: fail");
      end
      $finish;
   end

   // Far beyond the slowest correct run, including every idle and stall.
   initial begin
      #5ms;
      $display("Timed out with %0d quotients outstanding.", sb.pending());
      $display("status: fail");
      $finish;
   end

endmodule
